/* src/gwoc_pkg.sv */
`default_nettype none

package gwoc_pkg;

    // Grid geometry default
    localparam int MAX_COLS_DEF = 128;

    // Word characters of the reset pattern
    localparam logic [7:0] CH_S = 8'h73;
    localparam logic [7:0] CH_A = 8'h61;
    localparam logic [7:0] CH_B = 8'h62;

    localparam logic [7:0]  ROW_WIDTH_RST = 8'd128;
    localparam logic [31:0] WORD_RST      = {CH_S, CH_A, CH_B, CH_A};

    localparam logic [23:0] TOTAL_MAX = 24'hFF_FFFF;
    localparam logic [1:0]  ROWS_FULL = 2'd3;

    // Configuration register map
    localparam int          CFG_IDX_W      = 8;
    localparam logic [7:0]  CFG_ROW_WIDTH  = 8'd0;
    localparam logic [7:0]  CFG_WORD_CHARS = 8'd1;

    // Column words are {row r-1, row r-2, row r-3} for the item's column,
    // as they stand before that item writes its character.
    typedef struct packed {
        logic [23:0] w0;    // column c
        logic [23:0] w1;    // column c+1
        logic [23:0] w2;    // column c+2
        logic [23:0] w3;    // column c+3
        logic [23:0] h1;    // column c-1
        logic [23:0] h2;    // column c-2
        logic [23:0] h3;    // column c-3
    } t_win_view;

    typedef struct packed {
        logic        commit;   // one word scored, write back its column
        logic        start;    // reload the lookahead window
        logic [23:0] wr_word;  // shifted column word to store
    } t_win_cmd;

endpackage

`default_nettype wire

/* src/grid_word_occurrence_counter_core.sv */
`default_nettype none

// Grid word counter. Characters of a grid arrive in raster order, one word
// per handshake, and each word returns one result: the number of matches of
// the four-character search pattern (register word_chars, first character in
// the top byte) that complete at it, the saturating running total for the
// frame, and frame_done echoing end_of_frame. Matches are counted down,
// right, down-right and up-right; an up-right match is scored at its first
// character, all others at their last. Rows are row_width characters wide
// (0 acts as 1, anything above MAX_COLS acts as MAX_COLS). Throughput is one
// word per clock unless reloading or stalled; input and result are registered.
// The three previous rows live in one MAX_COLS x 24-bit line memory, one
// column word holding all three rows; its single read port fetches the column
// three words ahead for each accepted word into a lookahead window. That
// window is rebuilt after reset, after a word flagged end_of_frame and after
// every row_width write: the input stalls while it reloads. The line memory is
// not cleared; matches need three complete rows of the current frame, so stale
// contents never count. Write configuration only while no word is in flight.
// The running total restarts at zero after each end_of_frame word.

module grid_word_occurrence_counter_core #(
    parameter int MAX_COLS = gwoc_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // character input
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_ch,
    input  logic                           i_end_of_frame,
    // result output
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [2:0]                     o_hits_here,
    output logic [23:0]                    o_total_matches,
    output logic                           o_frame_done,
    // configuration writes
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [gwoc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);

    import gwoc_pkg::*;

    localparam int CW = $clog2(MAX_COLS);

    // effective row width: zero reads as one, clamp to the line memory
    function automatic logic [CW:0] f_eff_width(input logic [7:0] rw);
        logic [CW:0] v;
        if (rw == 8'd0) begin
            v = (CW+1)'(1);
        end else if (32'(rw) > 32'(MAX_COLS)) begin
            v = (CW+1)'(MAX_COLS);
        end else begin
            v = (CW+1)'(rw);
        end
        return v;
    endfunction

    // configuration
    logic [CW:0]   r_w;
    logic [31:0]   r_word;
    logic          cfg_we;
    logic          width_we;

    // input register
    logic          r_in_v;
    logic [7:0]    r_ch;
    logic          r_eof;

    // frame state
    logic [CW-1:0] r_col;
    logic [1:0]    r_rows;
    logic [23:0]   r_total;
    logic [23:0]   r_recent;

    // result register
    logic          r_out_v;
    logic [2:0]    r_hits;
    logic [23:0]   r_out_total;
    logic          r_done;

    logic          adv;
    logic          busy;
    logic          close0;
    logic          close1;
    logic [CW-1:0] col;
    logic [CW:0]   col_nx;
    logic [1:0]    rows_eff;
    logic [1:0]    rows_nx;
    logic [23:0]   recent_eff;
    logic [2:0]    hits;
    logic [24:0]   sum;
    logic [23:0]   total_nx;
    t_win_cmd      win_cmd;
    t_win_view     view;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid;
    assign width_we    = cfg_we && (i_cfg_index == CFG_ROW_WIDTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= f_eff_width(ROW_WIDTH_RST);
            r_word <= WORD_RST;
        end else if (cfg_we) begin
            case (i_cfg_index)
                CFG_ROW_WIDTH:  r_w    <= f_eff_width(i_cfg_data[7:0]);
                CFG_WORD_CHARS: r_word <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline: input register -> score -> result register. The result
    // register parts the two sides, so a new word enters while a result waits
    // as long as the result will be taken at the same edge.
    assign adv     = r_in_v && !busy && (!r_out_v || i_ready);
    assign o_ready = !r_in_v || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (o_ready) begin
            r_in_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ch  <= i_ch;
            r_eof <= i_end_of_frame;
        end
    end

    // A column count at or past the width (width lowered mid-row) closes
    // the row before this character.
    always_comb begin
        close0     = ({1'b0, r_col} >= r_w);
        col        = close0 ? '0 : r_col;
        recent_eff = close0 ? '0 : r_recent;
        if (close0 && r_rows != ROWS_FULL) begin
            rows_eff = r_rows + 2'd1;
        end else begin
            rows_eff = r_rows;
        end
        col_nx = {1'b0, col} + (CW+1)'(1);
        close1 = (col_nx >= r_w);
        if (close1 && rows_eff != ROWS_FULL) begin
            rows_nx = rows_eff + 2'd1;
        end else begin
            rows_nx = rows_eff;
        end
        sum      = {1'b0, r_total} + 25'(hits);
        total_nx = sum[24] ? TOTAL_MAX : sum[23:0];
    end

    gwoc_match #(
        .CW (CW)
    ) u_match (
        .i_view   (view),
        .i_cur    (r_ch),
        .i_word   (r_word),
        .i_recent (recent_eff),
        .i_col    (col),
        .i_w      (r_w),
        .i_full   (rows_eff == ROWS_FULL),
        .o_hits   (hits)
    );

    // column word moves down one row: new char on top, row r-3 drops out
    always_comb begin
        win_cmd.commit  = adv;
        win_cmd.start   = (adv && r_eof) || width_we;
        win_cmd.wr_word = {r_ch, view.w0[23:16], view.w0[15:8]};
    end

    gwoc_window #(
        .MAX_COLS (MAX_COLS),
        .CW       (CW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (win_cmd),
        .i_wr_col (col),
        .i_c0     (col),
        .i_w      (r_w),
        .o_view   (view),
        .o_busy   (busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_rows   <= '0;
            r_total  <= '0;
            r_recent <= '0;
        end else if (adv) begin
            if (r_eof) begin
                r_col    <= '0;
                r_rows   <= '0;
                r_total  <= '0;
                r_recent <= '0;
            end else begin
                r_col    <= close1 ? '0 : col_nx[CW-1:0];
                r_rows   <= rows_nx;
                r_total  <= total_nx;
                r_recent <= close1 ? '0 : {recent_eff[15:0], r_ch};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_out_v <= 1'b1;
        end else if (i_ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_hits      <= hits;
            r_out_total <= total_nx;
            r_done      <= r_eof;
        end
    end

    assign o_valid         = r_out_v;
    assign o_hits_here     = r_hits;
    assign o_total_matches = r_out_total;
    assign o_frame_done    = r_done;

endmodule

`default_nettype wire

/* src/gwoc_line_mem.sv */
`default_nettype none

module gwoc_line_mem #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);

    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // old data on a same-address read; the window forwards around it
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* src/gwoc_window.sv */
`default_nettype none

module gwoc_window #(
    parameter int MAX_COLS = 128,
    parameter int CW       = 7
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gwoc_pkg::t_win_cmd  i_cmd,
    input  logic [CW-1:0]       i_wr_col,
    input  logic [CW-1:0]       i_c0,
    input  logic [CW:0]         i_w,
    output gwoc_pkg::t_win_view o_view,
    output logic                o_busy
);

    import gwoc_pkg::*;

    typedef enum logic [1:0] {
        S_RUN,
        S_START,
        S_FILL
    } t_fill_state;

    t_fill_state r_state;
    logic [1:0]  r_cnt;
    logic [CW-1:0] r_push_tag;
    logic        r_byp_v;
    logic [23:0] r_byp;

    logic [23:0]   r_wd [3];
    logic [CW-1:0] r_tag [4];
    logic [23:0]   r_h [3];

    logic          push;
    logic          mem_re;
    logic [CW-1:0] mem_raddr;
    logic [23:0]   mem_rdata;
    logic [23:0]   w3_eff;
    logic [CW-1:0] tag_nx;
    logic [CW-1:0] push_nx;
    logic [CW:0]   tag_inc;
    logic [CW:0]   push_inc;

    assign push = (r_state == S_FILL);

    // next column in raster order, wrapping at the row width
    always_comb begin
        tag_inc  = {1'b0, r_tag[3]} + (CW+1)'(1);
        push_inc = {1'b0, r_push_tag} + (CW+1)'(1);
        tag_nx   = (tag_inc >= i_w) ? '0 : tag_inc[CW-1:0];
        push_nx  = (push_inc >= i_w) ? '0 : push_inc[CW-1:0];
    end

    assign mem_re    = i_cmd.commit || push;
    assign mem_raddr = push ? r_push_tag : tag_nx;
    assign w3_eff    = r_byp_v ? r_byp : mem_rdata;

    gwoc_line_mem #(
        .DEPTH (MAX_COLS),
        .AW    (CW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit),
        .i_waddr (i_wr_col),
        .i_wdata (i_cmd.wr_word),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // refill sequencer: four reads rebuild the lookahead after a restart
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_START;
            r_cnt      <= '0;
            r_push_tag <= '0;
            r_byp_v    <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_byp_v <= (tag_nx == i_wr_col);
            end else if (push) begin
                r_byp_v <= 1'b0;
            end
            if (i_cmd.start) begin
                r_state <= S_START;
            end else begin
                case (r_state)
                    S_START: begin
                        r_push_tag <= i_c0;
                        r_cnt      <= '0;
                        r_state    <= S_FILL;
                    end
                    S_FILL: begin
                        r_push_tag <= push_nx;
                        r_cnt      <= r_cnt + 2'd1;
                        if (r_cnt == 2'd3) begin
                            r_state <= S_RUN;
                        end
                    end
                    default: begin
                        r_state <= S_RUN;
                    end
                endcase
            end
        end
    end

    // window shift; words whose column is being written take the new word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_wd[0]  <= (r_tag[1] == i_wr_col) ? i_cmd.wr_word : r_wd[1];
            r_wd[1]  <= (r_tag[2] == i_wr_col) ? i_cmd.wr_word : r_wd[2];
            r_wd[2]  <= (r_tag[3] == i_wr_col) ? i_cmd.wr_word : w3_eff;
            r_tag[0] <= r_tag[1];
            r_tag[1] <= r_tag[2];
            r_tag[2] <= r_tag[3];
            r_tag[3] <= tag_nx;
            r_byp    <= i_cmd.wr_word;
            r_h[0]   <= r_wd[0];
            r_h[1]   <= r_h[0];
            r_h[2]   <= r_h[1];
        end else if (push) begin
            r_wd[0]  <= r_wd[1];
            r_wd[1]  <= r_wd[2];
            r_wd[2]  <= w3_eff;
            r_tag[0] <= r_tag[1];
            r_tag[1] <= r_tag[2];
            r_tag[2] <= r_tag[3];
            r_tag[3] <= r_push_tag;
        end
    end

    always_comb begin
        o_view.w0 = r_wd[0];
        o_view.w1 = r_wd[1];
        o_view.w2 = r_wd[2];
        o_view.w3 = w3_eff;
        o_view.h1 = r_h[0];
        o_view.h2 = r_h[1];
        o_view.h3 = r_h[2];
    end

    assign o_busy = (r_state != S_RUN);

endmodule

`default_nettype wire

/* src/gwoc_match.sv */
`default_nettype none

module gwoc_match #(
    parameter int CW = 7
) (
    input  gwoc_pkg::t_win_view i_view,
    input  logic [7:0]          i_cur,
    input  logic [31:0]         i_word,
    input  logic [23:0]         i_recent,
    input  logic [CW-1:0]       i_col,
    input  logic [CW:0]         i_w,
    input  logic                i_full,
    output logic [2:0]          o_hits
);

    import gwoc_pkg::*;

    logic [7:0] b0, b1, b2, b3;
    logic       col_ge3;
    logic       room3;
    logic       hit_down, hit_right, hit_diag, hit_up;

    assign b0 = i_word[31:24];
    assign b1 = i_word[23:16];
    assign b2 = i_word[15:8];
    assign b3 = i_word[7:0];

    assign col_ge3 = (i_col >= CW'(3));
    assign room3   = (({1'b0, i_col} + (CW+1)'(3)) < i_w);

    // column words: [23:16] row r-1, [15:8] row r-2, [7:0] row r-3
    assign hit_down  = i_full && i_view.w0[7:0] == b0 && i_view.w0[15:8] == b1
                       && i_view.w0[23:16] == b2 && i_cur == b3;
    assign hit_right = col_ge3 && i_recent[23:16] == b0 && i_recent[15:8] == b1
                       && i_recent[7:0] == b2 && i_cur == b3;
    assign hit_diag  = i_full && col_ge3 && i_view.h3[7:0] == b0
                       && i_view.h2[15:8] == b1 && i_view.h1[23:16] == b2
                       && i_cur == b3;
    // up-right ends at its first character, the last one to arrive
    assign hit_up    = i_full && room3 && i_cur == b0 && i_view.w1[23:16] == b1
                       && i_view.w2[15:8] == b2 && i_view.w3[7:0] == b3;

    assign o_hits = {2'b00, hit_down} + {2'b00, hit_right}
                  + {2'b00, hit_diag} + {2'b00, hit_up};

endmodule

`default_nettype wire

/* tb/tb_grid_word_occurrence_counter_core.sv */
module tb_grid_word_occurrence_counter_core;
    import gwoc_pkg::*;

    localparam int MAXC       = MAX_COLS_DEF;
    // Generous watchdog for a correct run
    localparam int CYCLE_CAP  = 200000;
    localparam int HOLD_LEN   = 300;

    // One character word on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       eof;
    } t_cell;

    // Expected result of one character word
    typedef struct packed {
        logic [2:0]  hits;
        logic [23:0] total;
        logic        done;
    } t_tally;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  in_ch = 8'h00;
    logic        in_eof = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ROW_WIDTH;
    logic [31:0] cfg_data = 32'h0;
    logic        o_ready;
    logic        o_valid;
    logic [2:0]  o_hits_here;
    logic [23:0] o_total_matches;
    logic        o_frame_done;
    logic        o_cfg_ready;

    grid_word_occurrence_counter_core #(.MAX_COLS(MAXC)) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (o_ready),
        .i_ch            (in_ch),
        .i_end_of_frame  (in_eof),
        .o_valid         (o_valid),
        .i_ready         (out_ready),
        .o_hits_here     (o_hits_here),
        .o_total_matches (o_total_matches),
        .o_frame_done    (o_frame_done),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping
    // ------------------------------------------------------------------
    t_cell  char_q[$];      // characters waiting to be offered
    t_tally tally_q[$];     // expected results, oldest first
    int     sent_count = 0; // characters taken from char_q by the driver
    int     seen_count = 0; // results taken by the monitor
    int     miss_count = 0;
    int     cycles = 0;
    int     tx_idle_pct = 0;
    int     rx_idle_pct = 0;
    logic   hold_arm = 1'b0;
    int     hold_left = 0;

    // ------------------------------------------------------------------
    // Grid scorer: shadow copy of the block's registers and row history.
    // Rows r-1, r-2, r-3 share three rotating slots; the current row
    // overwrites row r-3 in place, so the bytes it displaces are kept in
    // shed_bytes for the down-right diagonal.
    // ------------------------------------------------------------------
    logic [7:0]  cfg_width;
    logic [31:0] cfg_word;
    logic [7:0]  line_buf [3][MAXC];
    logic [23:0] recent;
    logic [23:0] shed_bytes;
    logic [23:0] total;
    int          col_at;
    int          rows_done;
    int          slot_at;

    function automatic int eff_cols();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAXC) return MAXC;
        return int'(cfg_width);
    endfunction

    function automatic logic [7:0] cell_at(input int slot, input int col);
        if (col >= MAXC) return 8'h00;
        return line_buf[slot][col];
    endfunction

    task automatic close_row();
        col_at = 0;
        if (rows_done < 3) rows_done++;
        slot_at = (slot_at + 1) % 3;
        recent = '0;
        shed_bytes = '0;
    endtask

    task automatic clear_frame();
        recent = '0;
        shed_bytes = '0;
        total = '0;
        col_at = 0;
        rows_done = 0;
        slot_at = 0;
    endtask

    task automatic score_char(input logic [7:0] cur, input logic eof, output t_tally res);
        int w, c, s1, s2, s3, hits, sum;
        logic [7:0] b0, b1, b2, b3, old;
        bit full;
        w = eff_cols();
        b0 = cfg_word[31:24];
        b1 = cfg_word[23:16];
        b2 = cfg_word[15:8];
        b3 = cfg_word[7:0];
        // width may have dropped below the current column
        if (col_at >= w) close_row();
        c = col_at;
        s3 = slot_at;
        s2 = (slot_at + 1) % 3;
        s1 = (slot_at + 2) % 3;
        full = (rows_done >= 3);
        old = cell_at(s3, c);
        hits = 0;
        // down
        if (full && old == b0 && cell_at(s2, c) == b1 && cell_at(s1, c) == b2 && cur == b3)
            hits++;
        // right
        if (c >= 3 && recent[23:16] == b0 && recent[15:8] == b1 && recent[7:0] == b2
            && cur == b3)
            hits++;
        // down-right
        if (full && c >= 3 && shed_bytes[23:16] == b0 && cell_at(s2, c - 2) == b1
            && cell_at(s1, c - 1) == b2 && cur == b3)
            hits++;
        // up-right, scored at the word's first character
        if (full && c + 3 < w && cur == b0 && cell_at(s1, c + 1) == b1
            && cell_at(s2, c + 2) == b2 && cell_at(s3, c + 3) == b3)
            hits++;
        if (c < MAXC) line_buf[slot_at][c] = cur;
        shed_bytes = {shed_bytes[15:0], old};
        recent = {recent[15:0], cur};
        col_at++;
        if (col_at >= w) close_row();
        sum = int'(total) + hits;
        total = (sum > int'(TOTAL_MAX)) ? TOTAL_MAX : 24'(sum);
        res.hits = 3'(hits);
        res.total = total;
        res.done = eof;
        if (eof) clear_frame();
    endtask

    task automatic log_miss(input string msg);
        miss_count++;
        if (miss_count <= 10) $display("MISMATCH: %s", msg);
    endtask

    // ------------------------------------------------------------------
    // Driver: offers queued characters, holds valid until taken, and
    // scores each word at the edge it is accepted.
    // ------------------------------------------------------------------
    t_cell  cur_job;
    t_tally fresh;

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_ready) begin
                score_char(in_ch, in_eof, fresh);
                tally_q.push_back(fresh);
            end
            if (!in_valid || o_ready) begin
                if (char_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    cur_job = char_q.pop_front();
                    sent_count++;
                    in_valid <= 1'b1;
                    in_ch <= cur_job.ch;
                    in_eof <= cur_job.eof;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: random back-pressure plus the long hold-off, and the
    // field-by-field compare against the oldest expectation.
    // ------------------------------------------------------------------
    t_tally want;

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_valid && out_ready) begin
                seen_count++;
                if (tally_q.size() == 0) begin
                    log_miss($sformatf("unexpected result: hits %0d total %0d done %0b",
                                       o_hits_here, o_total_matches, o_frame_done));
                end else begin
                    want = tally_q.pop_front();
                    if (o_hits_here !== want.hits || o_total_matches !== want.total
                        || o_frame_done !== want.done) begin
                        log_miss($sformatf(
                            "result %0d: exp %0d/%0d/%0b got %0d/%0d/%0b (hits/total/done)",
                            seen_count, want.hits, want.total, want.done,
                            o_hits_here, o_total_matches, o_frame_done));
                    end
                end
            end
            out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Hold-off counter for the receiver, armed by a one-cycle pulse
    always @(posedge clk) begin
        if (hold_arm) begin
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Watchdog
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_ROW_WIDTH:  cfg_width = val[7:0];
            CFG_WORD_CHARS: cfg_word = val;
            default: ;
        endcase
    endtask

    // Block is idle once every launched word has returned
    task automatic wait_quiet();
        while (char_q.size() != 0 || seen_count < sent_count) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_char(input logic [7:0] ch, input logic eof);
        t_cell item;
        item.ch = ch;
        item.eof = eof;
        char_q.push_back(item);
    endtask

    // Mostly letters of the current word so matches are dense
    function automatic logic [7:0] next_char(input bit noisy);
        if (noisy || $urandom_range(99) < 12) return 8'($urandom);
        return cfg_word[8 * $urandom_range(0, 3) +: 8];
    endfunction

    task automatic queue_chars(input int n, input bit noisy, input bit closing);
        for (int i = 0; i < n; i++) put_char(next_char(noisy), closing && (i == n - 1));
    endtask

    // Several full rows, sometimes ending mid-row
    task automatic queue_frame(input bit noisy, output int n);
        int w;
        w = eff_cols();
        n = $urandom_range(3, 6) * w + $urandom_range(0, w - 1);
        queue_chars(n, noisy, 1'b1);
    endtask

    function automatic logic [7:0] pick_width();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 3));
        return 8'($urandom_range(4, 10));
    endfunction

    function automatic logic [31:0] pick_word();
        logic [7:0]  x, y;
        logic [31:0] wd;
        x = 8'($urandom);
        y = 8'($urandom);
        case ($urandom_range(0, 5))
            0: wd = WORD_RST;
            1: wd = {x, x, x, x};
            2: wd = $urandom;
            default: begin
                for (int i = 0; i < 4; i++) wd[8 * i +: 8] = $urandom_range(0, 1) ? x : y;
            end
        endcase
        return wd;
    endfunction

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int got, n;
        for (int s = 0; s < 3; s++)
            for (int k = 0; k < MAXC; k++) line_buf[s][k] = 8'h00;
        cfg_width = ROW_WIDTH_RST;
        cfg_word = WORD_RST;
        clear_frame();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset registers: one right match inside a wide first row
        put_char(CH_S, 1'b0);
        put_char(CH_A, 1'b0);
        put_char(CH_B, 1'b0);
        put_char(CH_A, 1'b1);
        wait_quiet();

        // Zero width acts as one column: a single down match, byte extremes
        write_reg(CFG_ROW_WIDTH, 32'd0);
        write_reg(CFG_WORD_CHARS, 32'h00FF_00FF);
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b0);
        put_char(8'h00, 1'b0);
        put_char(8'hFF, 1'b1);
        wait_quiet();

        // Uniform grid: four hits on one character, frame ends mid-row
        write_reg(CFG_ROW_WIDTH, 32'd7);
        write_reg(CFG_WORD_CHARS, {CH_A, CH_A, CH_A, CH_A});
        for (int i = 0; i < 25; i++) put_char(CH_A, i == 24);
        wait_quiet();

        // Random phases: no idling, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct <= (ph == 1) ? 55 : (ph == 3) ? 23 : 0;
            rx_idle_pct <= (ph == 2) ? 55 : (ph == 3) ? 23 : 0;
            for (int k = 0; k < 2; k++) begin
                write_reg(CFG_ROW_WIDTH, {24'h0, pick_width()});
                write_reg(CFG_WORD_CHARS, pick_word());
                got = 0;
                while (got < 36) begin
                    queue_frame($urandom_range(0, 9) == 0, n);
                    got += n;
                end
                // long receiver hold while the sender keeps pushing
                if (ph == 0 && k == 1) begin
                    @(posedge clk);
                    hold_arm <= 1'b1;
                    @(posedge clk);
                    hold_arm <= 1'b0;
                end
                wait_quiet();
            end
        end

        // Width lowered mid-row: row closes before the next character.
        // The sender also pauses here until every result is back.
        write_reg(CFG_ROW_WIDTH, 32'd8);
        write_reg(CFG_WORD_CHARS, pick_word());
        queue_chars(2 * 8 + 6, 1'b0, 1'b0);
        wait_quiet();
        write_reg(CFG_ROW_WIDTH, 32'd5);
        queue_chars(3 * 5 + 2, 1'b0, 1'b1);
        wait_quiet();

        // Width register above the column count clamps; row wraps at MAXC
        write_reg(CFG_ROW_WIDTH, 32'd255);
        write_reg(CFG_WORD_CHARS, pick_word());
        queue_chars(MAXC + 32, 1'b0, 1'b1);
        wait_quiet();

        repeat (8) @(posedge clk);
        if (tally_q.size() != 0) log_miss($sformatf("%0d results never came", tally_q.size()));
        if (miss_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* filelist.f */
src/gwoc_pkg.sv
src/gwoc_line_mem.sv
src/gwoc_window.sv
src/gwoc_match.sv
src/grid_word_occurrence_counter_core.sv
tb/tb_grid_word_occurrence_counter_core.sv
